>>> sv/key_edge_multi_tap_tracker_defines.svh
// assertion macros shared by the key tracker rtl
`ifndef KEY_EDGE_MULTI_TAP_TRACKER_DEFINES_SVH
`define KEY_EDGE_MULTI_TAP_TRACKER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define KEMT_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("kemt check failed");

// next-cycle implication, checked out of reset
`define KEMT_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("kemt check failed");

`endif

>>> sv/kemt_pkg.sv
// shared types and codes for the key edge and multi-tap tracker
package kemt_pkg;

    // item operation codes carried in s_tuser
    typedef enum logic [2:0] {
        OP_EVENT       = 3'd0,
        OP_LATCH       = 3'd1,
        OP_CONSUME     = 3'd2,
        OP_CONSUME_ALL = 3'd3,
        OP_QUERY       = 3'd4
    } op_t;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_LOOKUP,
        ST_MODIFY
    } state_t;

    // fixed field widths
    localparam int KEY_W     = 11;
    localparam int TIME_W    = 32;
    localparam int TAP_OUT_W = 8;
    localparam int MS_W      = 16;

endpackage

>>> sv/key_edge_multi_tap_tracker.sv
// key edge and multi-tap tracker top level with its key table memory
//
//  channel | dir | handshake                  | payload
//  s_      | in  | s_tvalid / s_tready        | s_tdata, s_tuser (operation)
//  m_      | out | m_tvalid / m_tready        | m_tdata
//  apb     | in  | psel, penable, pwrite, ... | multi_tap_ms at byte address 0
//
// key event, consume key and query: one read of the key's entry, and for key event and
// consume key one write-back of it, in the single-port-read table memory
// frame latch and consume all: a sweep over every entry, then a read of the item's key
// after reset a clearing pass zeroes every table entry; s_tready stays low
// a result waits in the output register; the next item is taken meanwhile and
// stalls only in its modify step until that register is free
`include "key_edge_multi_tap_tracker_defines.svh"

module key_edge_multi_tap_tracker
    import kemt_pkg::*;
#(
    parameter int KEY_COUNT = 512,
    parameter int TAP_BITS  = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    // key_code[10:0], goes_down[11], event_time[43:12], include_consumed[44]
    input  logic [47:0] s_tdata,
    // operation[2:0]
    input  logic [2:0]  s_tuser,
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    // key_valid[0], edge_down[1], is_down[2], was_pressed[3], was_released[4],
    // tap_count[12:5], is_consumed[13]
    output logic [15:0] m_tdata,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(KEY_COUNT - 1);
    localparam logic [TAP_BITS-1:0] TAP_MAX  = '1;
    localparam logic [TAP_BITS-1:0] TAP_ONE  = TAP_BITS'(1);

    // one table entry per key
    typedef struct packed {
        logic                press_seen;
        logic [TIME_W-1:0]   last_press_time;
        logic [TAP_BITS-1:0] run_length;
        logic                consumed;
        logic [TAP_BITS-1:0] taps_latched;
        logic                released_latched;
        logic                pressed_latched;
        logic                down_latched;
        logic [TAP_BITS-1:0] taps_pending;
        logic                released_pending;
        logic                pressed_pending;
        logic                live_level;
    } entry_t;

    localparam int ENT_W = $bits(entry_t);

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 sw_valid_reg;
    logic [IDX_W-1:0]     sw_addr_reg;

    logic [2:0]           op_reg;
    logic [IDX_W-1:0]     key_reg;
    logic                 key_valid_reg;
    logic                 down_reg;
    logic [TIME_W-1:0]    time_reg;
    logic                 incl_reg;

    logic [MS_W-1:0]      multi_tap_ms_reg;
    logic                 m_valid_reg;
    logic [15:0]          m_data_reg;

    logic [ENT_W-1:0]     mem [KEY_COUNT];
    logic [ENT_W-1:0]     rd_data_reg;
    logic                 rd_en, wr_en;
    logic [IDX_W-1:0]     rd_addr, wr_addr;
    logic [ENT_W-1:0]     wr_data;

    logic                 accept;
    logic                 out_load;
    logic [KEY_W-1:0]     in_key;
    logic                 in_valid;

    entry_t               cur_ent, mod_ent, sw_ent;
    logic [TIME_W-1:0]    gap;
    logic                 cont;
    logic [TAP_BITS-1:0]  run_inc, run_new;
    logic                 edge_flag;
    logic                 open_view;
    logic                 mod_write;
    logic [TAP_BITS+7:0]  tap_ext;
    logic [15:0]          out_data;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, multi_tap_ms_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            multi_tap_ms_reg <= MS_W'(250);
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
        begin
            multi_tap_ms_reg <= pwdata[MS_W-1:0];
        end
    end

    // input decode
    assign in_key   = s_tdata[KEY_W-1:0];
    assign in_valid = !in_key[KEY_W-1] && ({22'd0, in_key[9:0]} < KEY_COUNT);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // item capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= s_tuser;
            key_reg       <= in_key[IDX_W-1:0];
            key_valid_reg <= in_valid;
            down_reg      <= s_tdata[11];
            time_reg      <= s_tdata[43:12];
            incl_reg      <= s_tdata[44];
        end
    end

    // table memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // read-modify of one key entry
    always_comb
    begin
        cur_ent   = entry_t'(rd_data_reg);
        mod_ent   = cur_ent;
        edge_flag = 1'b0;
        gap       = time_reg - cur_ent.last_press_time;
        cont      = cur_ent.press_seen && (gap <= {16'd0, multi_tap_ms_reg});
        run_inc   = (cur_ent.run_length == TAP_MAX) ? TAP_MAX
                                                    : cur_ent.run_length + TAP_ONE;
        run_new   = cont ? run_inc : TAP_ONE;
        case (op_reg)
            OP_EVENT:
            begin
                if (cur_ent.live_level != down_reg)
                begin
                    mod_ent.live_level = down_reg;
                    if (down_reg)
                    begin
                        edge_flag               = 1'b1;
                        mod_ent.pressed_pending = 1'b1;
                        mod_ent.run_length      = run_new;
                        mod_ent.last_press_time = time_reg;
                        mod_ent.press_seen      = 1'b1;
                        mod_ent.taps_pending    = run_new;
                    end
                    else
                    begin
                        mod_ent.released_pending = 1'b1;
                    end
                end
            end
            OP_CONSUME:
            begin
                mod_ent.consumed = 1'b1;
            end
            default:
            begin
                mod_ent = cur_ent;
            end
        endcase
    end

    // result word from the updated entry
    always_comb
    begin
        open_view = incl_reg || !mod_ent.consumed;
        tap_ext   = {8'd0, mod_ent.taps_latched};
        if (key_valid_reg)
        begin
            out_data = {2'b00,
                        mod_ent.consumed,
                        mod_ent.consumed ? 8'd0 : tap_ext[7:0],
                        open_view && mod_ent.released_latched,
                        open_view && mod_ent.pressed_latched,
                        open_view && mod_ent.down_latched,
                        edge_flag && (op_reg == OP_EVENT),
                        1'b1};
        end
        else
        begin
            out_data = 16'd0;
        end
    end

    // whole-table sweep update
    always_comb
    begin
        sw_ent = entry_t'(rd_data_reg);
        if (op_reg == OP_LATCH)
        begin
            sw_ent.consumed         = sw_ent.consumed && sw_ent.down_latched;
            sw_ent.down_latched     = sw_ent.live_level;
            sw_ent.pressed_latched  = sw_ent.pressed_pending;
            sw_ent.released_latched = sw_ent.released_pending;
            sw_ent.taps_latched     = sw_ent.taps_pending;
            sw_ent.pressed_pending  = 1'b0;
            sw_ent.released_pending = 1'b0;
            sw_ent.taps_pending     = '0;
        end
        else
        begin
            sw_ent.consumed = sw_ent.consumed || sw_ent.down_latched
                              || sw_ent.pressed_latched || sw_ent.released_latched;
        end
    end

    assign out_load  = (state_reg == ST_MODIFY) && (!m_valid_reg || m_tready);
    assign mod_write = out_load && key_valid_reg
                       && ((op_reg == OP_EVENT) || (op_reg == OP_CONSUME));

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            idx_reg      <= '0;
            sw_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            sw_valid_reg <= (state_reg == ST_SWEEP);
        end
    end

    always_ff @(posedge clk)
    begin
        sw_addr_reg <= idx_reg;
    end

    // next state and memory port control
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        rd_en      = 1'b0;
        rd_addr    = key_reg;
        wr_en      = 1'b0;
        wr_addr    = sw_addr_reg;
        wr_data    = sw_ent;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = '0;
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((s_tuser == OP_LATCH) || (s_tuser == OP_CONSUME_ALL))
                    begin
                        idx_next   = '0;
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = in_key[IDX_W-1:0];
                        state_next = ST_MODIFY;
                    end
                end
            end
            ST_SWEEP:
            begin
                rd_en    = 1'b1;
                rd_addr  = idx_reg;
                wr_en    = sw_valid_reg;
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                wr_en      = sw_valid_reg;
                state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                rd_en      = 1'b1;
                rd_addr    = key_reg;
                state_next = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                wr_en   = mod_write;
                wr_addr = key_reg;
                wr_data = mod_ent;
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= out_data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // checks
    `KEMT_ASSERT_NOW(a_no_rw_collide, rd_en && wr_en, rd_addr != wr_addr)
    `KEMT_ASSERT_NOW(a_clear_blocks_input, state_reg == ST_CLEAR, !s_tready)
    `KEMT_ASSERT_NEXT(a_load_shows_result, out_load, m_tvalid)
    `KEMT_ASSERT_NEXT(a_sweep_ends_drain, (state_reg == ST_SWEEP) && (idx_reg == LAST_IDX),
                      (state_reg == ST_DRAIN) && sw_valid_reg)

endmodule

>>> dv/key_edge_multi_tap_tracker_test.sv
// self-checking testbench for the key edge and multi-tap tracker
`timescale 1ns / 100ps

module key_edge_multi_tap_tracker_test;
    import kemt_pkg::*;

    localparam int KEYS         = 512;
    localparam int TAPS         = 8;
    localparam bit [8:0] TAP_SAT = 9'd255;
    localparam int RUN_LIMIT    = 500000;
    localparam int TAIL_CYCLES  = KEYS + 64;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [2:0] ADDR_MULTI_TAP = 3'd0;
    localparam logic [2:0] ADDR_UNUSED    = 3'd4;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam int MODE_RX_SLOW = 0;
    localparam int MODE_TX_SLOW = 1;
    localparam int MODE_NO_IDLE = 2;

    typedef struct packed {
        logic [2:0]  op;
        logic [10:0] key;
        logic        down;
        logic [31:0] stamp;
        logic        incl;
    } key_item_t;

    // same bit order as m_tdata[13:0]
    typedef struct packed {
        logic       is_consumed;
        logic [7:0] tap_count;
        logic       was_released;
        logic       was_pressed;
        logic       is_down;
        logic       edge_down;
        logic       key_valid;
    } key_view_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    key_edge_multi_tap_tracker #(
        .KEY_COUNT (KEYS),
        .TAP_BITS  (TAPS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    // key table shadow
    bit         live_down  [KEYS];
    bit         new_press  [KEYS];
    bit         new_release[KEYS];
    bit [7:0]   new_taps   [KEYS];
    bit         frame_down [KEYS];
    bit         frame_press[KEYS];
    bit         frame_rel  [KEYS];
    bit [7:0]   frame_taps [KEYS];
    bit         consumed   [KEYS];
    bit [7:0]   run_len    [KEYS];
    bit [31:0]  press_stamp[KEYS];
    bit         press_seen [KEYS];
    bit [15:0]  tap_window = 16'd250;

    key_item_t   item_q[$];
    key_view_t   view_q[$];
    key_item_t   on_bus;
    int unsigned mismatches = 0;
    int unsigned cycles     = 0;
    int          idle_mode  = MODE_RX_SLOW;
    bit          rx_hold_armed = 1'b0;

    // stimulus side: expected level per key and running clock
    bit          gen_level[KEYS];
    bit [31:0]   clock_ms = 32'd100;

    // apply one item to the shadow table and return the view it reports
    function automatic key_view_t track_key_item(input key_item_t it);
        key_view_t   v;
        int unsigned k;
        bit          ok;
        bit          open;
        bit [31:0]   gap;
        bit [8:0]    run;
        v  = '0;
        ok = !it.key[10] && (it.key[9:0] < KEYS);
        k  = {22'd0, it.key[9:0]};
        case (it.op)
            OP_EVENT:
            begin
                if (ok && live_down[k] != it.down)
                begin
                    live_down[k] = it.down;
                    if (!it.down)
                        new_release[k] = 1'b1;
                    else
                    begin
                        new_press[k] = 1'b1;
                        gap = it.stamp - press_stamp[k];
                        if (press_seen[k] && gap <= {16'd0, tap_window})
                            run = {1'b0, run_len[k]} + 9'd1;
                        else
                            run = 9'd1;
                        if (run > TAP_SAT)
                            run = TAP_SAT;
                        run_len[k]     = run[7:0];
                        press_stamp[k] = it.stamp;
                        press_seen[k]  = 1'b1;
                        new_taps[k]    = run[7:0];
                        v.edge_down    = 1'b1;
                    end
                end
            end
            OP_LATCH:
            begin
                for (int i = 0; i < KEYS; i++)
                begin
                    consumed[i]    = consumed[i] && frame_down[i];
                    frame_down[i]  = live_down[i];
                    frame_press[i] = new_press[i];
                    frame_rel[i]   = new_release[i];
                    frame_taps[i]  = new_taps[i];
                    new_press[i]   = 1'b0;
                    new_release[i] = 1'b0;
                    new_taps[i]    = 8'd0;
                end
            end
            OP_CONSUME:
            begin
                if (ok)
                    consumed[k] = 1'b1;
            end
            OP_CONSUME_ALL:
            begin
                for (int i = 0; i < KEYS; i++)
                    consumed[i] = consumed[i] || frame_down[i] || frame_press[i] ||
                                  frame_rel[i];
            end
            default: ;
        endcase
        if (!ok)
            return '0;
        open           = it.incl || !consumed[k];
        v.key_valid    = 1'b1;
        v.is_down      = open && frame_down[k];
        v.was_pressed  = open && frame_press[k];
        v.was_released = open && frame_rel[k];
        v.tap_count    = consumed[k] ? 8'd0 : frame_taps[k];
        v.is_consumed  = consumed[k];
        return v;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    function automatic int sender_idle_pct();
        if (idle_mode == MODE_RX_SLOW)
            return 27;
        else if (idle_mode == MODE_TX_SLOW)
            return 69;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (idle_mode == MODE_RX_SLOW)
            return 69;
        else if (idle_mode == MODE_TX_SLOW)
            return 27;
        return 0;
    endfunction

    // input driver: predicts on each accepted transfer, then offers the next item
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                view_q.insert(view_q.size(), track_key_item(on_bus));
            if (!s_tvalid || s_tready)
            begin
                if (item_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct())
                begin
                    on_bus   = item_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, on_bus.incl, on_bus.stamp, on_bus.down, on_bus.key};
                    s_tuser  <= on_bus.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // output monitor with its own long hold-off
    int unsigned hold_count = 0;
    bit          hold_done  = 1'b0;
    always @(posedge clk)
    begin
        key_view_t got;
        key_view_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[13:0];
            if (view_q.size() == 0)
                report_mismatch("unexpected transfer", m_tdata, 0);
            else
            begin
                want = view_q.pop_front();
                check_field("key_valid", got.key_valid, want.key_valid);
                check_field("edge_down", got.edge_down, want.edge_down);
                check_field("is_down", got.is_down, want.is_down);
                check_field("was_pressed", got.was_pressed, want.was_pressed);
                check_field("was_released", got.was_released, want.was_released);
                check_field("tap_count", got.tap_count, want.tap_count);
                check_field("is_consumed", got.is_consumed, want.is_consumed);
            end
        end
        if (rx_hold_armed && !hold_done)
        begin
            m_tready <= 1'b0;
            hold_count++;
            if (hold_count >= HOLD_CYCLES)
                hold_done = 1'b1;
        end
        else
            m_tready <= rst_n && ($urandom_range(0, 99) >= receiver_idle_pct());
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MULTI_TAP)
            tap_window = value[15:0];
    endtask

    // block is idle once nothing is queued, offered or outstanding
    task automatic wait_quiet();
        @(negedge clk);
        while (item_q.size() != 0 || s_tvalid || view_q.size() != 0)
            @(negedge clk);
    endtask

    function automatic void push_item(input logic [2:0] op, input logic [10:0] key,
                                      input bit down, input bit [31:0] stamp,
                                      input bit incl);
        key_item_t it;
        it.op    = op;
        it.key   = key;
        it.down  = down;
        it.stamp = stamp;
        it.incl  = incl;
        item_q.insert(item_q.size(), it);
    endfunction

    // mostly a few busy keys, sometimes any key, sometimes outside the table
    function automatic logic [10:0] pick_key();
        int r;
        int unsigned hot[8] = '{0, 1, 2, 3, 100, 255, 510, 511};
        r = $urandom_range(0, 99);
        if (r < 78)
            return 11'(hot[$urandom_range(0, 7)]);
        else if (r < 90)
            return 11'($urandom_range(0, KEYS - 1));
        return 11'($urandom_range(KEYS, 2047));
    endfunction

    // clock steps around the tap window, with jumps back and far away
    function automatic bit [31:0] next_stamp();
        int          r;
        int unsigned span;
        span = {16'd0, tap_window};
        r    = $urandom_range(0, 99);
        if (r < 72)
            clock_ms = clock_ms + $urandom_range(0, span + span / 2 + 3);
        else if (r < 84)
            clock_ms = clock_ms + span + $urandom_range(0, 1);
        else if (r < 93)
            clock_ms = clock_ms - $urandom_range(1, 40);
        else
            clock_ms = $urandom;
        return clock_ms;
    endfunction

    function automatic void push_event(input logic [10:0] key, input bit down,
                                       input bit [31:0] stamp);
        if (!key[10] && key[9:0] < KEYS)
            gen_level[key[9:0]] = down;
        push_item(OP_EVENT, key, down, stamp, 1'($urandom_range(0, 1)));
    endfunction

    function automatic void push_random_item();
        int          r;
        logic [10:0] key;
        bit          down;
        r   = $urandom_range(0, 99);
        key = pick_key();
        if (r < 62)
        begin
            if (!key[10] && key[9:0] < KEYS && $urandom_range(0, 99) < 80)
                down = !gen_level[key[9:0]];
            else
                down = 1'($urandom_range(0, 1));
            push_event(key, down, next_stamp());
        end
        else if (r < 76)
            push_item(OP_QUERY, key, 1'($urandom_range(0, 1)), $urandom,
                      1'($urandom_range(0, 1)));
        else if (r < 84)
            push_item(OP_CONSUME, key, 1'($urandom_range(0, 1)), $urandom,
                      1'($urandom_range(0, 1)));
        else if (r < 89)
            push_item(OP_LATCH, key, 1'($urandom_range(0, 1)), $urandom,
                      1'($urandom_range(0, 1)));
        else if (r < 93)
            push_item(OP_CONSUME_ALL, key, 1'($urandom_range(0, 1)), $urandom,
                      1'($urandom_range(0, 1)));
        else if (r < 96)
            push_item(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), key,
                      1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
        else
            // noise: every field drawn at random
            push_item(3'($urandom_range(0, 7)), 11'($urandom_range(0, 2047)),
                      1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
    endfunction

    task automatic run_phase(input int mode, input bit [15:0] window, input int count);
        wait_quiet();
        apb_write(ADDR_MULTI_TAP, {16'd0, window});
        @(negedge clk);
        idle_mode = mode;
        for (int i = 0; i < count; i++)
            push_random_item();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed part with the reset window of 250 ms
        @(negedge clk);
        idle_mode = MODE_RX_SLOW;
        push_item(OP_QUERY, 11'd0, 1'b0, 32'd0, 1'b0);
        push_event(11'd5, 1'b1, 32'd1000);
        push_event(11'd5, 1'b1, 32'd1010);
        push_event(11'd5, 1'b0, 32'd1050);
        push_event(11'd5, 1'b1, 32'd1250);
        push_event(11'd5, 1'b0, 32'd1300);
        push_event(11'd5, 1'b1, 32'd1501);
        push_item(OP_LATCH, 11'd0, 1'b0, 32'd0, 1'b0);
        push_item(OP_QUERY, 11'd5, 1'b0, 32'hFFFF_FFFF, 1'b0);
        // timestamp wrap keeps the run going
        push_event(11'd511, 1'b1, 32'hFFFF_FFF0);
        push_event(11'd511, 1'b0, 32'hFFFF_FFF8);
        push_event(11'd511, 1'b1, 32'h0000_0010);
        // press earlier than the previous one restarts the run
        push_event(11'd7, 1'b1, 32'd5000);
        push_event(11'd7, 1'b0, 32'd5010);
        push_event(11'd7, 1'b1, 32'd4990);
        // codes outside the table
        push_item(OP_EVENT, 11'h7FF, 1'b1, 32'd6000, 1'b1);
        push_item(OP_EVENT, 11'd512, 1'b1, 32'd6000, 1'b1);
        push_item(OP_CONSUME, 11'd1023, 1'b0, 32'd0, 1'b1);
        push_item(OP_QUERY, 11'h400, 1'b1, 32'hFFFF_FFFF, 1'b1);
        push_item(OP_CONSUME, 11'd5, 1'b0, 32'd0, 1'b0);
        push_item(OP_QUERY, 11'd5, 1'b0, 32'd0, 1'b1);
        push_item(OP_LATCH, 11'd5, 1'b0, 32'd0, 1'b0);
        push_item(OP_CONSUME_ALL, 11'd511, 1'b0, 32'd0, 1'b0);
        push_item(OP_SPARE_FIRST, 11'd511, 1'b1, 32'd0, 1'b0);
        push_item(OP_SPARE_FIRST + 3'd1, 11'd7, 1'b0, 32'd0, 1'b1);
        push_item(OP_SPARE_LAST, 11'd7, 1'b1, 32'd0, 1'b0);
        // release of a key that is already up
        push_event(11'd0, 1'b0, 32'd7000);

        // write to an unused address, then a zero window
        wait_quiet();
        apb_write(ADDR_UNUSED, $urandom);
        run_phase(MODE_RX_SLOW, 16'd0, 550);

        // widest window: a long tap burst runs the count into saturation
        run_phase(MODE_TX_SLOW, 16'hFFFF, 200);
        if (gen_level[3])
            push_event(11'd3, 1'b0, next_stamp());
        for (int i = 0; i < 260; i++)
        begin
            clock_ms = clock_ms + $urandom_range(0, 1000);
            push_event(11'd3, 1'b1, clock_ms);
            clock_ms = clock_ms + $urandom_range(0, 1000);
            push_event(11'd3, 1'b0, clock_ms);
        end
        push_item(OP_LATCH, 11'd3, 1'b0, 32'd0, 1'b0);
        push_item(OP_QUERY, 11'd3, 1'b0, 32'd0, 1'b0);

        // mid window, no idling; the receiver first holds off for a long stretch
        wait_quiet();
        apb_write(ADDR_MULTI_TAP, $urandom_range(100, 2000));
        @(negedge clk);
        idle_mode     = MODE_NO_IDLE;
        rx_hold_armed = 1'b1;
        for (int i = 0; i < 620; i++)
            push_random_item();

        wait_quiet();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (view_q.size() != 0)
            report_mismatch("leftover results", view_q.size(), 0);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
